>>> hdl/afd_pkg.sv
// Shared types and constants for the ARQ receive ack and duplicate filter.
// Used by afd_decide, the top level and afd_checker; depends on nothing.
package afd_pkg;

  localparam int NUM_SOURCES = 256;
  localparam int IDX_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int ID_W        = 8;
  localparam int SEQ_W       = 8;
  localparam int KIND_W      = 2;

  localparam logic [ID_W-1:0] BROADCAST_RESET = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_INPUT  = 2'd1,
    KIND_SERIAL = 2'd2,
    KIND_OTHER  = 2'd3
  } pkt_kind_t;

  // One result of the filter, as it is registered toward the output.
  typedef struct packed {
    logic             send_ack;
    logic [ID_W-1:0]  ack_target;
    logic [SEQ_W-1:0] ack_sequence;
    logic             is_duplicate;
    logic             deliver;
    logic             deliver_kind;
  } afd_result_t;

  // Table update requested by the decision logic.
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [SEQ_W-1:0] wr_seq;
  } afd_update_t;

endpackage

>>> hdl/afd_seq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Holds the last sequence per source; no package dependency.
module afd_seq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/afd_decide.sv
// Ack, duplicate and delivery decision for one header whose table entry has been read.
// Depends on afd_pkg.
module afd_decide (
  input  logic [afd_pkg::KIND_W-1:0] kind,
  input  logic [afd_pkg::ID_W-1:0]   source_id,
  input  logic [afd_pkg::ID_W-1:0]   dest_id,
  input  logic [afd_pkg::SEQ_W-1:0]  sequence_req,
  input  logic [afd_pkg::ID_W-1:0]   broadcast_id,
  input  logic                       known,
  input  logic [afd_pkg::SEQ_W-1:0]  last_seq,
  output afd_pkg::afd_result_t       result,
  output afd_pkg::afd_update_t       update
);

  afd_pkg::pkt_kind_t kind_e;
  logic               not_ack;
  logic               in_range;
  logic               seen;

  always_comb begin
    kind_e   = afd_pkg::pkt_kind_t'(kind);
    not_ack  = (kind_e != afd_pkg::KIND_ACK);
    in_range = ({1'b0, source_id} < (afd_pkg::ID_W + 1)'(afd_pkg::NUM_SOURCES));
    seen     = in_range && known && (last_seq == sequence_req);

    result.send_ack     = not_ack && (dest_id != broadcast_id);
    result.ack_target   = result.send_ack ? source_id : '0;
    result.ack_sequence = result.send_ack ? sequence_req : '0;
    result.is_duplicate = not_ack && seen;
    result.deliver      = not_ack && !seen &&
                          ((kind_e == afd_pkg::KIND_INPUT) || (kind_e == afd_pkg::KIND_SERIAL));
    result.deliver_kind = result.deliver && (kind_e == afd_pkg::KIND_SERIAL);

    update.wr_en  = not_ack && in_range && !seen;
    update.wr_idx = source_id[afd_pkg::IDX_W-1:0];
    update.wr_seq = sequence_req;
  end

endmodule

>>> hdl/arq_receive_ack_duplicate_filter_unit.sv
// Top level of the ARQ receive ack and duplicate filter.
// Depends on afd_pkg, afd_seq_ram and afd_decide.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one validated packet header
//   per request: kind, source, destination and sequence. The result channel
//   (out_valid / out_stall) returns exactly one result request per header: the
//   ack to send, the duplicate flag and the delivery decision.
//   A request moves when valid is high and stall is low at a rising clock edge.
//   Throughput is one header per cycle while the receiver does not stall. An
//   accepted header is registered into the decision stage as the sequence memory
//   is read; the decision is made from the stage registers and the result is
//   registered in the output register, which raises out_valid. A write to an entry
//   that the following header reads in the same cycle is forwarded, so
//   back-to-back headers from one source are filtered correctly.
//   When the receiver stalls, the result holds in the output register, the
//   header behind it holds in the decision stage and in_stall rises; nothing
//   is lost or repeated.
//   Synchronous active-low reset clears the per-source valid bits at once (no
//   clearing pass), empties the pipeline and sets the broadcast id to 255. Write the
//   broadcast id via cfg_wr_en / cfg_wr_data only while idle; this is not enforced.
module arq_receive_ack_duplicate_filter_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // Configuration
  input  logic                       cfg_wr_en,
  input  logic [afd_pkg::ID_W-1:0]   cfg_wr_data,
  // Header input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [afd_pkg::KIND_W-1:0] in_packet_kind,
  input  logic [afd_pkg::ID_W-1:0]   in_source_id,
  input  logic [afd_pkg::ID_W-1:0]   in_dest_id,
  input  logic [afd_pkg::SEQ_W-1:0]  in_sequence_req,
  // Result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_send_ack,
  output logic [afd_pkg::ID_W-1:0]   out_ack_target,
  output logic [afd_pkg::SEQ_W-1:0]  out_ack_sequence,
  output logic                       out_is_duplicate,
  output logic                       out_deliver,
  output logic                       out_deliver_kind
);

  // Configuration register.
  logic [afd_pkg::ID_W-1:0] bcast_r, bcast_nxt;

  // Decision stage holding the header whose table entry is being read.
  logic                       s1_valid_r, s1_valid_nxt;
  logic [afd_pkg::KIND_W-1:0] s1_kind_r;
  logic [afd_pkg::ID_W-1:0]   s1_src_r;
  logic [afd_pkg::ID_W-1:0]   s1_dst_r;
  logic [afd_pkg::SEQ_W-1:0]  s1_seq_r;

  // Forwarding of the table write that happened at the edge of the read.
  logic                       fwd_valid_r, fwd_valid_nxt;
  logic [afd_pkg::IDX_W-1:0]  fwd_idx_r;
  logic [afd_pkg::SEQ_W-1:0]  fwd_seq_r;

  // Per-source valid bits, cleared by reset.
  logic [afd_pkg::NUM_SOURCES-1:0] known_r, known_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  afd_pkg::afd_result_t out_res_r;

  logic                      accept;
  logic                      s1_adv;
  logic                      s1_fire;
  logic [afd_pkg::SEQ_W-1:0] ram_rdata;
  logic [afd_pkg::SEQ_W-1:0] last_seq;
  logic [afd_pkg::IDX_W-1:0] s1_idx;
  afd_pkg::afd_result_t      dec_res;
  afd_pkg::afd_update_t      dec_upd;
  logic                      tbl_we;

  // The decision stage moves on when the output register is empty or being taken.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign accept   = in_valid && !in_stall;
  assign s1_idx   = s1_src_r[afd_pkg::IDX_W-1:0];
  assign tbl_we   = s1_fire && dec_upd.wr_en;

  afd_seq_ram #(
    .DEPTH (afd_pkg::NUM_SOURCES),
    .WIDTH (afd_pkg::SEQ_W),
    .AW    (afd_pkg::IDX_W)
  ) u_seq_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (dec_upd.wr_idx),
    .wdata (dec_upd.wr_seq),
    .re    (accept),
    .raddr (in_source_id[afd_pkg::IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // The memory returned old data if the entry was written at the same edge as the read.
  assign last_seq = (fwd_valid_r && (fwd_idx_r == s1_idx)) ? fwd_seq_r : ram_rdata;

  afd_decide u_decide (
    .kind         (s1_kind_r),
    .source_id    (s1_src_r),
    .dest_id      (s1_dst_r),
    .sequence_req (s1_seq_r),
    .broadcast_id (bcast_r),
    .known        (known_r[s1_idx]),
    .last_seq     (last_seq),
    .result       (dec_res),
    .update       (dec_upd)
  );

  always_comb begin
    bcast_nxt = cfg_wr_en ? cfg_wr_data : bcast_r;

    s1_valid_nxt = accept || (s1_valid_r && !s1_adv);

    // Only refreshed when a read is issued, so a stalled header keeps its forward.
    fwd_valid_nxt = accept ? tbl_we : fwd_valid_r;

    known_nxt = known_r;
    if (tbl_we) begin
      known_nxt[dec_upd.wr_idx] = 1'b1;
    end

    out_valid_nxt = s1_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcast_r     <= afd_pkg::BROADCAST_RESET;
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      known_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bcast_r     <= bcast_nxt;
      s1_valid_r  <= s1_valid_nxt;
      fwd_valid_r <= fwd_valid_nxt;
      known_r     <= known_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_packet_kind;
      s1_src_r  <= in_source_id;
      s1_dst_r  <= in_dest_id;
      s1_seq_r  <= in_sequence_req;
      fwd_idx_r <= dec_upd.wr_idx;
      fwd_seq_r <= dec_upd.wr_seq;
    end
    if (s1_fire) begin
      out_res_r <= dec_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_send_ack     = out_res_r.send_ack;
  assign out_ack_target   = out_res_r.ack_target;
  assign out_ack_sequence = out_res_r.ack_sequence;
  assign out_is_duplicate = out_res_r.is_duplicate;
  assign out_deliver      = out_res_r.deliver;
  assign out_deliver_kind = out_res_r.deliver_kind;

endmodule

>>> hdl/afd_checker.sv
// Port-level checks for the ARQ receive ack and duplicate filter, bound to the top level.
// Depends on afd_pkg and arq_receive_ack_duplicate_filter_unit.
module afd_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_send_ack,
  input logic [afd_pkg::ID_W-1:0]   out_ack_target,
  input logic [afd_pkg::SEQ_W-1:0]  out_ack_sequence,
  input logic                       out_is_duplicate,
  input logic                       out_deliver,
  input logic                       out_deliver_kind
);

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ack_target) &&
      $stable(out_ack_sequence) && $stable(out_is_duplicate) && $stable(out_deliver))
    else $error("stalled result changed");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A duplicate is never delivered.
  a_dup_no_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_duplicate |-> !out_deliver && !out_deliver_kind)
    else $error("duplicate delivered");

  // Ack fields are zero when no ack is requested.
  a_no_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_send_ack |-> (out_ack_target == '0) && (out_ack_sequence == '0))
    else $error("ack fields set without ack");

  // Serial kind is only flagged together with delivery.
  a_kind_with_deliver: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_deliver_kind |-> out_deliver)
    else $error("deliver kind without deliver");

endmodule

bind arq_receive_ack_duplicate_filter_unit afd_checker u_afd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_send_ack     (out_send_ack),
  .out_ack_target   (out_ack_target),
  .out_ack_sequence (out_ack_sequence),
  .out_is_duplicate (out_is_duplicate),
  .out_deliver      (out_deliver),
  .out_deliver_kind (out_deliver_kind)
);
